[hw/rtl/gcdlcm_pkg.sv]
// gcdlcm_pkg: shared types, constants and microcode rom for the gcd/lcm unit
package gcdlcm_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int LCM_W  = 63;
    localparam int CNT_W  = 5;
    localparam int PC_W   = 4;

    typedef logic [PC_W-1:0] step_t;

    // datapath actions, one per control word
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DIV_XY,
        ACT_REM,
        ACT_SET_G,
        ACT_DIV_AG,
        ACT_MUL,
        ACT_SET_M,
        ACT_OUT
    } act_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_Y_ZERO,
        COND_AB_ZERO,
        COND_DIV_BUSY,
        COND_MUL_BUSY,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ctl_word_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic y_zero;
        logic ab_zero;
        logic div_busy;
        logic mul_busy;
        logic out_busy;
    } stat_t;

    // step addresses
    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_TEST      = 4'd1;
    localparam step_t STEP_DIV       = 4'd2;
    localparam step_t STEP_DIV_WAIT  = 4'd3;
    localparam step_t STEP_REM       = 4'd4;
    localparam step_t STEP_GCD       = 4'd5;
    localparam step_t STEP_QUOT      = 4'd6;
    localparam step_t STEP_QUOT_WAIT = 4'd7;
    localparam step_t STEP_MUL       = 4'd8;
    localparam step_t STEP_MUL_WAIT  = 4'd9;
    localparam step_t STEP_LCM       = 4'd10;
    localparam step_t STEP_OUT       = 4'd11;
    localparam step_t STEP_RET       = 4'd12;

    // microcode rom: euclid loop, then quotient a/g, then product with b
    function automatic ctl_word_t ucode(input step_t pc);
        ctl_word_t w;
        unique case (pc)
            STEP_IDLE:      w = '{ACT_LOAD,   COND_NO_INPUT, STEP_IDLE};
            STEP_TEST:      w = '{ACT_NONE,   COND_Y_ZERO,   STEP_GCD};
            STEP_DIV:       w = '{ACT_DIV_XY, COND_NEXT,     STEP_IDLE};
            STEP_DIV_WAIT:  w = '{ACT_NONE,   COND_DIV_BUSY, STEP_DIV_WAIT};
            STEP_REM:       w = '{ACT_REM,    COND_ALWAYS,   STEP_TEST};
            STEP_GCD:       w = '{ACT_SET_G,  COND_AB_ZERO,  STEP_OUT};
            STEP_QUOT:      w = '{ACT_DIV_AG, COND_NEXT,     STEP_IDLE};
            STEP_QUOT_WAIT: w = '{ACT_NONE,   COND_DIV_BUSY, STEP_QUOT_WAIT};
            STEP_MUL:       w = '{ACT_MUL,    COND_NEXT,     STEP_IDLE};
            STEP_MUL_WAIT:  w = '{ACT_NONE,   COND_MUL_BUSY, STEP_MUL_WAIT};
            STEP_LCM:       w = '{ACT_SET_M,  COND_NEXT,     STEP_IDLE};
            STEP_OUT:       w = '{ACT_OUT,    COND_OUT_BUSY, STEP_OUT};
            STEP_RET:       w = '{ACT_NONE,   COND_ALWAYS,   STEP_IDLE};
            default:        w = '{ACT_NONE,   COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/gcdlcm_div.sv]
// gcdlcm_div: restoring divider, one quotient bit per cycle
module gcdlcm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [gcdlcm_pkg::DATA_W-1:0]  dividend,
    input  logic [gcdlcm_pkg::DATA_W-1:0]  divisor,
    output logic                           busy,
    output logic [gcdlcm_pkg::DATA_W-1:0]  quotient,
    output logic [gcdlcm_pkg::DATA_W-1:0]  remainder
);
    import gcdlcm_pkg::*;

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_W-1:0]     quo_reg, quo_next;
    logic [DATA_W-1:0]     rem_reg, rem_next;
    logic [DATA_W-1:0]     dsr_reg, dsr_next;
    logic [DATA_W:0]       trial;
    logic [DATA_W:0]       diff;

    // one shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DATA_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/gcdlcm_mul.sv]
// gcdlcm_mul: shift-add multiplier, one multiplier bit per cycle
module gcdlcm_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [gcdlcm_pkg::DATA_W-1:0]  mcand,
    input  logic [gcdlcm_pkg::DATA_W-1:0]  mplier,
    output logic                           busy,
    output logic [gcdlcm_pkg::PROD_W-1:0]  product
);
    import gcdlcm_pkg::*;

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PROD_W-1:0]     acc_reg, acc_next;
    logic [PROD_W-1:0]     mcd_reg, mcd_next;
    logic [DATA_W-1:0]     mpl_reg, mpl_next;

    // one add-shift step
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mcd_next  = mcd_reg;
        mpl_next  = mpl_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            mcd_next  = {{(PROD_W-DATA_W){1'b0}}, mcand};
            mpl_next  = mplier;
        end
        else if (busy_reg)
        begin
            if (mpl_reg[0])
            begin
                acc_next = acc_reg + mcd_reg;
            end
            mcd_next = {mcd_reg[PROD_W-2:0], 1'b0};
            mpl_next = {1'b0, mpl_reg[DATA_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcd_reg <= mcd_next;
        mpl_reg <= mpl_next;
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

[hw/rtl/gcdlcm_seq.sv]
// gcdlcm_seq: step counter, microcode lookup and conditional jumps
module gcdlcm_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gcdlcm_pkg::stat_t      stat,
    output gcdlcm_pkg::ctl_word_t  ctl
);
    import gcdlcm_pkg::*;

    step_t     pc_reg, pc_next;
    ctl_word_t word;
    logic      take;

    // fetch the control word of the current step
    assign word = ucode(pc_reg);

    // evaluate the jump condition
    always_comb
    begin
        unique case (word.cond)
            COND_NEXT:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_INPUT: take = !stat.in_valid;
            COND_Y_ZERO:   take = stat.y_zero;
            COND_AB_ZERO:  take = stat.ab_zero;
            COND_DIV_BUSY: take = stat.div_busy;
            COND_MUL_BUSY: take = stat.mul_busy;
            COND_OUT_BUSY: take = stat.out_busy;
            default:       take = 1'b1;
        endcase
    end

    // next step
    always_comb
    begin
        if (take)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctl = word;

endmodule

[hw/rtl/gcd_lcm_unit_top.sv]
// gcd_lcm_unit_top: gcd and lcm of two signed operands, microcoded datapath
//
// Input channel: operand_a and operand_b with in_valid / in_stall. An item is
// taken on a rising edge with in_valid high and in_stall low. in_stall is low
// only while the sequencer sits in its idle step.
// Output channel: divisor_out = gcd(|a|,|b|) and multiple_out = lcm(|a|,|b|)
// with out_valid / out_stall, held in an output register.
// Sequence: each Euclid remainder step runs the shared divider on x / y; the
// lcm then runs the divider on a / g and the shift-add multiplier on the
// quotient and b. With a zero operand the quotient and product steps are
// skipped.
// One item is in work at a time; after the result enters the output register
// the sequencer returns to idle through its return step and takes the next
// item even while that result still waits. If the receiver stalls, the
// sequencer holds at its output step until the register is free.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, drops
// out_valid and stops the divider and multiplier; data registers are not reset.
module gcd_lcm_unit_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [gcdlcm_pkg::DATA_W-1:0]  operand_a,
    input  logic signed [gcdlcm_pkg::DATA_W-1:0]  operand_b,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [gcdlcm_pkg::DATA_W-1:0]  divisor_out,
    output logic        [gcdlcm_pkg::LCM_W-1:0]   multiple_out
);
    import gcdlcm_pkg::*;

    ctl_word_t          ctl;
    stat_t              stat;
    logic [DATA_W-1:0]  a_reg, b_reg, x_reg, y_reg, g_reg;
    logic [LCM_W-1:0]   m_reg;
    logic [DATA_W-1:0]  div_out_reg;
    logic [LCM_W-1:0]   mul_out_reg;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  abs_a, abs_b;
    logic               div_start, mul_start;
    logic [DATA_W-1:0]  div_dend, div_dsr;
    logic               div_busy, mul_busy;
    logic [DATA_W-1:0]  quotient, remainder;
    logic [PROD_W-1:0]  product;
    logic               out_busy;

    // absolute values as unsigned magnitudes
    assign abs_a = operand_a[DATA_W-1] ? (DATA_W'(0) - operand_a) : operand_a;
    assign abs_b = operand_b[DATA_W-1] ? (DATA_W'(0) - operand_b) : operand_b;

    assign in_stall = (ctl.act != ACT_LOAD);
    assign out_busy = out_valid_reg && out_stall;

    // status for conditional jumps
    always_comb
    begin
        stat.in_valid = in_valid;
        stat.y_zero   = (y_reg == '0);
        stat.ab_zero  = (a_reg == '0) || (b_reg == '0);
        stat.div_busy = div_busy;
        stat.mul_busy = mul_busy;
        stat.out_busy = out_busy;
    end

    gcdlcm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // divider operand select: x / y in the loop, a / g for the lcm
    assign div_start = (ctl.act == ACT_DIV_XY) || (ctl.act == ACT_DIV_AG);
    assign div_dend  = (ctl.act == ACT_DIV_AG) ? a_reg : x_reg;
    assign div_dsr   = (ctl.act == ACT_DIV_AG) ? g_reg : y_reg;
    assign mul_start = (ctl.act == ACT_MUL);

    gcdlcm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dend),
        .divisor   (div_dsr),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    gcdlcm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (quotient),
        .mplier  (b_reg),
        .busy    (mul_busy),
        .product (product)
    );

    // working registers driven by the control word
    always_ff @(posedge clk)
    begin
        unique case (ctl.act)
            ACT_LOAD:
            begin
                if (in_valid)
                begin
                    a_reg <= abs_a;
                    b_reg <= abs_b;
                    x_reg <= abs_a;
                    y_reg <= abs_b;
                end
            end
            ACT_REM:
            begin
                x_reg <= y_reg;
                y_reg <= remainder;
            end
            ACT_SET_G:
            begin
                g_reg <= x_reg;
                m_reg <= '0;
            end
            ACT_SET_M:
            begin
                m_reg <= product[LCM_W-1:0];
            end
            ACT_OUT:
            begin
                if (!out_busy)
                begin
                    div_out_reg <= g_reg;
                    mul_out_reg <= m_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((ctl.act == ACT_OUT) && !out_busy)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign divisor_out  = div_out_reg;
    assign multiple_out = mul_out_reg;

endmodule
